@@ rtl/cltok_pkg.sv @@
// cltok_pkg: shared types and constants for the command line tokenizer
// holds transaction structs, result kinds, scan modes and character codes
// no dependencies
`default_nettype none

package cltok_pkg;

    // character codes the scanner reacts to
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;

    // most results one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // scanner mode
    typedef enum logic [1:0] {
        MODE_GAP    = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2
    } t_mode;

    // input transaction
    typedef struct packed {
        logic [7:0] in_char;
        logic       line_end;
    } t_item;

    // output transaction
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_char;
        logic       line_error;
        logic       run_last;
    } t_result;

    // all results of one input byte, slot 0 goes out first
    typedef struct packed {
        logic [1:0]                      count;
        t_result [MAX_RESULTS-1:0]       res;
    } t_bundle;

endpackage

`default_nettype wire

@@ rtl/command_line_tokenizer_core.sv @@
// command_line_tokenizer_core: top level of the command line tokenizer
// depends on cltok_pkg, cltok_front, cltok_queue, cltok_back
//
// Splits a command line, fed one byte per transaction, into space separated
// arguments and streams token characters, token ends and one line end per
// line; a quote opening a token makes a quoted argument, a backslash escapes
// the next byte, and the line end result flags an unclosed quote. The
// scanner takes one byte per cycle while the bundle queue is not full; each
// byte causes zero to three results and the result side delivers one result
// per cycle while the consumer pops, so the sustained input rate is one byte
// per cycle as long as bytes average at most one result, and the bundle queue
// of QUEUE_DEPTH entries absorbs bursts beyond that. The first result of a
// byte passes through the bundle queue and the output register, and a byte
// with several results is handed out one result at a time.
`default_nettype none

module command_line_tokenizer_core
    import cltok_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire t_item   i_item,
    output logic         empty,
    input  wire logic    pop,
    output t_result      o_result
);

    logic    accept;
    logic    bundle_push;
    t_bundle bundle_in;
    t_bundle bundle_head;
    logic    queue_full, queue_empty;
    logic    head_pop;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    // scanner
    cltok_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .o_bundle_push (bundle_push),
        .o_bundle      (bundle_in)
    );

    // bundle queue
    cltok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bundle_push),
        .i_data  (bundle_in),
        .i_pop   (head_pop),
        .o_data  (bundle_head),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // result sequencer
    cltok_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (bundle_head),
        .i_head_valid (!queue_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

@@ rtl/cltok_front.sv @@
// cltok_front: scanner state machine, classifies each byte into a result bundle
// depends on cltok_pkg
`default_nettype none

module cltok_front
    import cltok_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_item   i_item,
    output logic         o_bundle_push,
    output t_bundle      o_bundle
);

    t_mode r_mode, n_mode;
    logic  r_esc, n_esc;
    logic  r_has, n_has;
    logic  r_odd, n_odd;

    // state after the byte itself, before any line end
    t_mode take_mode;
    logic  take_esc, take_has, take_odd;
    logic  take_emit_char, take_emit_end;
    logic  is_nul, finish;

    assign is_nul = (i_item.in_char == CH_NUL);
    assign finish = is_nul || i_item.line_end;

    // byte classification and next state
    always_comb begin
        take_mode      = r_mode;
        take_esc       = r_esc;
        take_has       = r_has;
        take_odd       = r_odd;
        take_emit_char = 1'b0;
        take_emit_end  = 1'b0;
        if (!is_nul) begin
            unique case (r_mode)
                MODE_PLAIN: begin
                    if (r_esc) begin
                        take_esc       = 1'b0;
                        take_has       = 1'b1;
                        take_emit_char = 1'b1;
                    end else if (i_item.in_char == CH_SPACE) begin
                        take_mode     = MODE_GAP;
                        take_has      = 1'b0;
                        take_emit_end = 1'b1;
                    end else if (i_item.in_char == CH_BACKSLASH) begin
                        take_esc = 1'b1;
                    end else begin
                        take_has       = 1'b1;
                        take_emit_char = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (r_esc) begin
                        take_esc       = 1'b0;
                        take_has       = 1'b1;
                        take_emit_char = 1'b1;
                    end else if (i_item.in_char == CH_BACKSLASH) begin
                        take_esc = 1'b1;
                    end else if (i_item.in_char == CH_QUOTE) begin
                        take_odd      = ~r_odd;
                        take_mode     = MODE_GAP;
                        take_has      = 1'b0;
                        take_emit_end = 1'b1;
                    end else begin
                        take_has       = 1'b1;
                        take_emit_char = 1'b1;
                    end
                end
                default: begin
                    // between tokens, also the unused mode code
                    take_mode = MODE_GAP;
                    take_esc  = 1'b0;
                    take_has  = 1'b0;
                    if (i_item.in_char == CH_QUOTE) begin
                        take_odd  = ~r_odd;
                        take_mode = MODE_QUOTED;
                    end else if (i_item.in_char == CH_BACKSLASH) begin
                        take_mode = MODE_PLAIN;
                        take_esc  = 1'b1;
                    end else if (i_item.in_char != CH_SPACE) begin
                        take_mode      = MODE_PLAIN;
                        take_has       = 1'b1;
                        take_emit_char = 1'b1;
                    end
                end
            endcase
        end

        // a line end returns everything to reset values
        if (finish) begin
            n_mode = MODE_GAP;
            n_esc  = 1'b0;
            n_has  = 1'b0;
            n_odd  = 1'b0;
        end else begin
            n_mode = take_mode;
            n_esc  = take_esc;
            n_has  = take_has;
            n_odd  = take_odd;
        end
    end

    // result bundle for this byte
    always_comb begin
        logic [1:0] cnt;
        cnt      = 2'd0;
        o_bundle = '0;
        if (take_emit_char) begin
            o_bundle.res[cnt].out_kind = KIND_CHAR;
            o_bundle.res[cnt].out_char = i_item.in_char;
            cnt = cnt + 2'd1;
        end
        if (take_emit_end) begin
            o_bundle.res[cnt].out_kind = KIND_TOKEN_END;
            cnt = cnt + 2'd1;
        end
        if (finish) begin
            if ((take_mode == MODE_PLAIN || take_mode == MODE_QUOTED) && take_has) begin
                o_bundle.res[cnt].out_kind = KIND_TOKEN_END;
                cnt = cnt + 2'd1;
            end
            o_bundle.res[cnt].out_kind   = KIND_LINE_END;
            o_bundle.res[cnt].line_error = take_odd;
            cnt = cnt + 2'd1;
        end
        if (cnt != 2'd0) begin
            o_bundle.res[cnt - 2'd1].run_last = 1'b1;
        end
        o_bundle.count = cnt;
        o_bundle_push  = i_accept && (cnt != 2'd0);
    end

    // scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_GAP;
            r_esc  <= 1'b0;
            r_has  <= 1'b0;
            r_odd  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_has  <= n_has;
            r_odd  <= n_odd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cltok_queue.sv @@
// cltok_queue: short bundle queue between scanner and result sequencer
// depends on cltok_pkg
`default_nettype none

module cltok_queue
    import cltok_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    input  wire logic    i_pop,
    output t_bundle      o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cltok_back.sv @@
// cltok_back: steps through the slots of each bundle into a registered output
// depends on cltok_pkg
`default_nettype none

module cltok_back
    import cltok_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_bundle i_head,
    input  wire logic    i_head_valid,
    output logic         o_head_pop,
    input  wire logic    i_pop,
    output logic         o_empty,
    output t_result      o_result
);

    t_result     r_out;
    logic        r_valid, n_valid;
    logic [1:0]  r_idx, n_idx;
    logic        load;
    logic        last_slot;

    // output register takes a new result when it is free or being drained
    assign load      = i_head_valid && (!r_valid || i_pop);
    assign last_slot = (r_idx == i_head.count - 2'd1);
    assign o_head_pop = load && last_slot;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = last_slot ? 2'd0 : r_idx + 2'd1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_head.res[r_idx];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

@@ verif/command_line_tokenizer_core_tb.sv @@
// command_line_tokenizer_core_tb: self-checking testbench for the command line tokenizer
// drives byte transactions through the push/full queue interface, predicts every result
// and checks it at the pop/empty side; depends on cltok_pkg and command_line_tokenizer_core
`timescale 1ns / 1ps

module command_line_tokenizer_core_tb
    import cltok_pkg::*;
();

    localparam int RANDOM_ITEMS = 420;
    localparam int TAIL_ITEMS   = 60;
    localparam int SETTLE_TICKS = 8;
    localparam int HANG_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_TICKS   = 60;
    localparam int HOLD_AFTER   = 150;

    // tokenizer predictor and store of expected results
    class token_scoreboard;
        t_mode   mode;
        bit      esc_pend;
        bit      has_chars;
        bit      quote_odd;
        t_result byte_q[$];
        t_result expected_q[$];
        int      n_mismatch;

        function new();
            n_mismatch = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode      = MODE_GAP;
            esc_pend  = 1'b0;
            has_chars = 1'b0;
            quote_odd = 1'b0;
        endfunction

        function void add(input logic [1:0] kind, input logic [7:0] ch, input logic err);
            t_result r;
            r.out_kind   = kind;
            r.out_char   = ch;
            r.line_error = err;
            r.run_last   = 1'b0;
            byte_q = {byte_q, r};
        endfunction

        // one non-zero byte through the scanner
        function void scan_byte(input logic [7:0] c);
            case (mode)
                MODE_PLAIN: begin
                    if (esc_pend) begin
                        esc_pend  = 1'b0;
                        has_chars = 1'b1;
                        add(KIND_CHAR, c, 1'b0);
                    end else if (c == CH_SPACE) begin
                        mode      = MODE_GAP;
                        has_chars = 1'b0;
                        add(KIND_TOKEN_END, 8'h00, 1'b0);
                    end else if (c == CH_BACKSLASH) begin
                        esc_pend = 1'b1;
                    end else begin
                        has_chars = 1'b1;
                        add(KIND_CHAR, c, 1'b0);
                    end
                end
                MODE_QUOTED: begin
                    if (esc_pend) begin
                        esc_pend  = 1'b0;
                        has_chars = 1'b1;
                        add(KIND_CHAR, c, 1'b0);
                    end else if (c == CH_BACKSLASH) begin
                        esc_pend = 1'b1;
                    end else if (c == CH_QUOTE) begin
                        quote_odd = ~quote_odd;
                        mode      = MODE_GAP;
                        has_chars = 1'b0;
                        add(KIND_TOKEN_END, 8'h00, 1'b0);
                    end else begin
                        has_chars = 1'b1;
                        add(KIND_CHAR, c, 1'b0);
                    end
                end
                default: begin
                    mode      = MODE_GAP;
                    esc_pend  = 1'b0;
                    has_chars = 1'b0;
                    if (c == CH_QUOTE) begin
                        quote_odd = ~quote_odd;
                        mode      = MODE_QUOTED;
                    end else if (c == CH_BACKSLASH) begin
                        mode     = MODE_PLAIN;
                        esc_pend = 1'b1;
                    end else if (c != CH_SPACE) begin
                        mode      = MODE_PLAIN;
                        has_chars = 1'b1;
                        add(KIND_CHAR, c, 1'b0);
                    end
                end
            endcase
        endfunction

        // close an open token that holds characters, then the line end
        function void end_line();
            if ((mode == MODE_PLAIN || mode == MODE_QUOTED) && has_chars)
                add(KIND_TOKEN_END, 8'h00, 1'b0);
            add(KIND_LINE_END, 8'h00, quote_odd);
            clear_line();
        endfunction

        // accepted input transaction
        function void note_item(input t_item it);
            byte_q.delete();
            if (it.in_char == CH_NUL) begin
                end_line();
            end else begin
                scan_byte(it.in_char);
                if (it.line_end)
                    end_line();
            end
            if (byte_q.size() > 0)
                byte_q[byte_q.size()-1].run_last = 1'b1;
            expected_q = {expected_q, byte_q};
        endfunction

        function void report(input string what, input t_result e, input t_result g);
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
                $display("%0t: %s: expected kind %0d char %h err %b last %b",
                         $realtime, what, e.out_kind, e.out_char, e.line_error, e.run_last);
                $display("    got kind %0d char %h err %b last %b",
                         g.out_kind, g.out_char, g.line_error, g.run_last);
            end
        endfunction

        // accepted output transaction
        function void check_result(input t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                report("unexpected result", '0, got);
            end else begin
                e = expected_q.pop_front();
                if (got.out_kind !== e.out_kind || got.out_char !== e.out_char ||
                    got.line_error !== e.line_error || got.run_last !== e.run_last)
                    report("result mismatch", e, got);
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_item   i_item;
    logic    empty;
    logic    pop;
    t_result o_result;

    token_scoreboard sb = new();
    int  n_sent = 0;
    bit  tail_phase = 1'b0;

    command_line_tokenizer_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // offer one byte and hold it until the block takes it
    task automatic send_item(input t_item it);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic sender_gap(input int ticks);
        push <= 1'b0;
        repeat (ticks) @(posedge i_clk);
    endtask

    // random idle burst unless in the tail
    task automatic maybe_gap();
        if (!tail_phase && $urandom_range(0, 5) == 0)
            sender_gap($urandom_range(1, 9));
    endtask

    // stop sending until every expected result is out, then let the pipe settle
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic send_text(input string s, input bit term);
        t_item it;
        for (int i = 0; i < s.len(); i++) begin
            it.in_char  = s[i];
            it.line_end = term && (i == s.len() - 1);
            maybe_gap();
            send_item(it);
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input bit le);
        t_item it;
        it.in_char  = c;
        it.line_end = le;
        maybe_gap();
        send_item(it);
    endtask

    // byte weighted toward the characters the scanner reacts to
    function automatic logic [7:0] pick_char();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)      return 8'($urandom_range(8'h61, 8'h7A));
        else if (sel < 58) return CH_SPACE;
        else if (sel < 70) return CH_QUOTE;
        else if (sel < 82) return CH_BACKSLASH;
        else               return 8'($urandom_range(1, 255));
    endfunction

    // well-formed line with random content, or noise now and then
    task automatic send_random_line();
        int          len;
        int unsigned how;
        len = $urandom_range(1, 12);
        how = $urandom_range(0, 9);
        if (how == 0) begin
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            for (int i = 0; i < len - 1; i++)
                send_byte(pick_char(), 1'b0);
            if (how < 6)
                send_byte(pick_char(), 1'b1);
            else if (how < 9)
                send_byte(CH_NUL, 1'($urandom_range(0, 1)));
            else
                send_byte(pick_char(), 1'b0);
        end
    endtask

    // result side: checks transactions and stalls in bursts or one long hold
    initial begin
        int stall_left;
        int seen;
        bit long_done;
        stall_left = 0;
        seen       = 0;
        long_done  = 1'b0;
        pop        = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_result(o_result);
                seen++;
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!long_done && seen >= HOLD_AFTER) begin
                long_done  = 1'b1;
                stall_left = HOLD_TICKS - 1;
                pop <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= HANG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_item it;
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        send_byte(CH_NUL, 1'b0);           // empty line
        send_text(" ", 1'b1);              // spaces only
        send_text("a b", 1'b1);            // plain tokens, line end inside a token
        send_text("\"\"", 1'b0);           // empty quoted token
        send_byte(CH_NUL, 1'b1);
        send_text("\"x y\"z", 1'b1);       // quoted with space, token right after quote
        send_text("a\"\\", 1'b1);          // quote inside plain token, trailing backslash
        send_text("\"\\\"", 1'b1);         // escaped quote inside open quote, unclosed
        send_byte(8'hFF, 1'b0);            // byte extremes
        send_byte(8'h01, 1'b1);
        send_text("\\", 1'b1);             // lone backslash, no token
        send_byte(CH_NUL, 1'b1);
        drain();

        // random lines, pausing midway until all results are out
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            if (n_sent >= RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            send_random_line();
            if (n_sent >= RANDOM_ITEMS / 2 && n_sent < RANDOM_ITEMS / 2 + 12)
                drain();
        end
        // close whatever line is still open
        it.in_char  = CH_NUL;
        it.line_end = 1'b1;
        send_item(it);

        // wait out the remaining results
        drain();
        if (sb.n_mismatch == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cltok_pkg.sv
rtl/cltok_front.sv
rtl/cltok_queue.sv
rtl/cltok_back.sv
rtl/command_line_tokenizer_core.sv
verif/command_line_tokenizer_core_tb.sv
